FILE: rtl/aprp_pkg.sv
// Shared constants and controller/datapath interface types for the
// attraction point radius prune block. No dependencies.
`default_nettype none

package aprp_pkg;

  localparam int APRP_POINTS     = 64;
  localparam int APRP_COORD_BITS = 16;

  localparam int ID_W      = 16;
  localparam int CFG_W     = 34;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INFLUENCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KILL      = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // append point
    logic clear;   // empty table
    logic query;   // latch branch end
    logic other;   // unknown mode, empty result
    logic issue;   // read entry at walk index
    logic finish;  // close the query transaction
  } aprp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cred_ok;    // room reserved for one more entry in flight
    logic cur_valid;  // valid bit at walk index
    logic busy;       // distance pipeline holds an entry
    logic fifo_full;
  } aprp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/attraction_point_radius_prune_top.sv
// Top level of the attraction point radius prune block: controller plus
// datapath and a few checks. Depends on aprp_pkg, aprp_ctrl, aprp_dp.
//
// Usage:
//   Input channel (in_valid/in_ready): mode, point_id, pos_x/y/z. Load (0)
//   appends a point, query (1) walks the table against a branch end, clear
//   (2) empties the table; mode 3 only returns an empty result.
//   Output channel (out_valid/out_ready): one result per load, clear or
//   unknown mode; a query returns one result per influencing point in table
//   order, or one empty result, with last set on the final one.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   index 0 = influence radius squared, 1 = kill distance squared.
// Sequencing:
//   Load, clear, unknown mode: accepted while idle with queue room; the result is
//   written to the queue as the input is accepted. Query: the walk reads one
//   entry per cycle while queue credit allows, through the read, square and
//   compare stages, then drains and closes; the next input follows the close.
// Reset: synchronous, clears valid bits, write pointer, queue and config;
//   no clearing pass over the store is needed.
// Stall: an 8-deep result queue decouples the sides; the walk pauses when
//   every queue slot is claimed by queued, in-flight or held-back results.
`default_nettype none

module attraction_point_radius_prune_top #(
  parameter int POINTS     = aprp_pkg::APRP_POINTS,
  parameter int COORD_BITS = aprp_pkg::APRP_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [aprp_pkg::MODE_W-1:0]    mode,
  input  logic [aprp_pkg::ID_W-1:0]      point_id,
  input  logic signed [COORD_BITS-1:0]   pos_x,
  input  logic signed [COORD_BITS-1:0]   pos_y,
  input  logic signed [COORD_BITS-1:0]   pos_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [aprp_pkg::ID_W-1:0]      found_id,
  output logic signed [COORD_BITS-1:0]   found_x,
  output logic signed [COORD_BITS-1:0]   found_y,
  output logic signed [COORD_BITS-1:0]   found_z,
  output logic                           in_range,
  output logic                           removed,
  output logic                           status,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aprp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aprp_pkg::CFG_W-1:0]     cfg_data
);
  import aprp_pkg::*;

  localparam int IW = (POINTS > 1) ? $clog2(POINTS) : 1;

  aprp_cmd_t     cmd;
  aprp_sts_t     st;
  logic [IW-1:0] idx;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  aprp_ctrl #(
    .POINTS (POINTS),
    .IW     (IW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .st       (st),
    .cmd      (cmd),
    .idx      (idx)
  );

  aprp_dp #(
    .POINTS     (POINTS),
    .COORD_BITS (COORD_BITS),
    .IW         (IW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .idx       (idx),
    .point_id  (point_id),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found_id  (found_id),
    .found_x   (found_x),
    .found_y   (found_y),
    .found_z   (found_z),
    .in_range  (in_range),
    .removed   (removed),
    .status    (status),
    .last      (last)
  );

  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.clear, cmd.query, cmd.other, cmd.issue, cmd.finish}))
    else $error("controller raised more than one command");

  // new transactions only start with the distance pipeline empty
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !st.busy)
    else $error("input accepted while entries in flight");

  // a read is only issued against a reserved queue slot
  a_issue_credit: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> st.cred_ok)
    else $error("entry issued without queue credit");

  // the closing result follows the last compare
  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!st.busy && !st.fifo_full))
    else $error("query closed with pipeline busy or queue full");

endmodule

`default_nettype wire

FILE: rtl/aprp_ctrl.sv
// Controller for the prune block: decodes input transactions and sequences
// the table walk. Depends on aprp_pkg.
`default_nettype none

module aprp_ctrl #(
  parameter int POINTS = aprp_pkg::APRP_POINTS,
  parameter int IW     = (POINTS > 1) ? $clog2(POINTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [aprp_pkg::MODE_W-1:0] mode,
  input  aprp_pkg::aprp_sts_t         st,
  output aprp_pkg::aprp_cmd_t         cmd,
  output logic [IW-1:0]               idx
);
  import aprp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [IW-1:0] idx_next;
  logic          acc;

  assign in_ready = (state == S_IDLE) && !st.fifo_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
        if (acc) begin
          unique case (mode)
            MODE_LOAD:  cmd.load  = 1'b1;
            MODE_CLEAR: cmd.clear = 1'b1;
            MODE_QUERY: begin
              cmd.query  = 1'b1;
              state_next = S_WALK;
            end
            default:    cmd.other = 1'b1;
          endcase
        end
      end
      S_WALK: begin
        if (st.cred_ok) begin
          cmd.issue = st.cur_valid;
          idx_next  = idx + 1'b1;
          if (idx == IW'(POINTS - 1)) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!st.busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!st.fifo_full) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/aprp_dp.sv
// Datapath for the prune block: config registers, point store, valid bits,
// distance pipeline, held-back result and result queue. Depends on aprp_pkg.
`default_nettype none

module aprp_dp #(
  parameter int POINTS     = aprp_pkg::APRP_POINTS,
  parameter int COORD_BITS = aprp_pkg::APRP_COORD_BITS,
  parameter int IW         = (POINTS > 1) ? $clog2(POINTS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [aprp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aprp_pkg::CFG_W-1:0]     cfg_data,
  input  aprp_pkg::aprp_cmd_t            cmd,
  input  logic [IW-1:0]                  idx,
  input  logic [aprp_pkg::ID_W-1:0]      point_id,
  input  logic signed [COORD_BITS-1:0]   pos_x,
  input  logic signed [COORD_BITS-1:0]   pos_y,
  input  logic signed [COORD_BITS-1:0]   pos_z,
  output aprp_pkg::aprp_sts_t            st,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [aprp_pkg::ID_W-1:0]      found_id,
  output logic signed [COORD_BITS-1:0]   found_x,
  output logic signed [COORD_BITS-1:0]   found_y,
  output logic signed [COORD_BITS-1:0]   found_z,
  output logic                           in_range,
  output logic                           removed,
  output logic                           status,
  output logic                           last
);
  import aprp_pkg::*;

  localparam int W   = COORD_BITS;
  localparam int EW  = ID_W + 3 * W;          // stored entry {id, x, y, z}
  localparam int RW  = EW + 4;                // result {entry, flags}
  localparam int QW  = 2 * W;                 // one squared difference
  localparam int SW  = 2 * W + 2;             // sum of three squares
  localparam int CW  = (SW > CFG_W) ? SW : CFG_W;
  localparam int WPW = $clog2(POINTS + 1);
  localparam int RSW = FIFO_CW + 1;

  localparam int B_LAST    = 0;
  localparam int B_STATUS  = 1;
  localparam int B_REMOVED = 2;
  localparam int B_INRANGE = 3;

  // configuration
  logic [CFG_W-1:0] influence_radius_sq, kill_distance_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      influence_radius_sq <= '0;
      kill_distance_sq    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INFLUENCE: influence_radius_sq <= cfg_data;
        REG_KILL:      kill_distance_sq    <= cfg_data;
        default: ;
      endcase
    end
  end

  // table
  logic [EW-1:0]     point_store [POINTS];
  logic [POINTS-1:0] entry_valid;
  logic [WPW-1:0]    write_pointer;
  logic              table_full;

  assign table_full = (write_pointer == WPW'(POINTS));

  always_ff @(posedge clk) begin
    if (cmd.load && !table_full) begin
      point_store[write_pointer[IW-1:0]] <= {point_id, pos_x, pos_y, pos_z};
    end
  end

  // branch end
  logic signed [W-1:0] br_x, br_y, br_z;

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      br_x <= pos_x;
      br_y <= pos_y;
      br_z <= pos_z;
    end
  end

  // stage 1: store read
  logic          s1_v;
  logic [IW-1:0] s1_idx;
  logic [EW-1:0] s1_data;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_data <= point_store[idx];
    end
    s1_idx <= idx;
  end

  // stage 2: squared differences
  logic signed [W:0]    dx, dy, dz;
  logic signed [SW-1:0] px, py, pz;
  logic                 s2_v;
  logic [IW-1:0]        s2_idx;
  logic [EW-1:0]        s2_data;
  logic [QW-1:0]        sq_x, sq_y, sq_z;

  assign dx = $signed({s1_data[3*W-1], s1_data[3*W-1 -: W]}) - $signed({br_x[W-1], br_x});
  assign dy = $signed({s1_data[2*W-1], s1_data[2*W-1 -: W]}) - $signed({br_y[W-1], br_y});
  assign dz = $signed({s1_data[W-1], s1_data[W-1:0]}) - $signed({br_z[W-1], br_z});
  assign px = SW'(dx) * SW'(dx);
  assign py = SW'(dy) * SW'(dy);
  assign pz = SW'(dz) * SW'(dz);

  always_ff @(posedge clk) begin
    sq_x    <= px[QW-1:0];
    sq_y    <= py[QW-1:0];
    sq_z    <= pz[QW-1:0];
    s2_data <= s1_data;
    s2_idx  <= s1_idx;
  end

  // compare
  logic [CW-1:0] dsum;
  logic          hit, kill;

  assign dsum = CW'(sq_x) + CW'(sq_y) + CW'(sq_z);
  assign hit  = s2_v && (dsum <= CW'(influence_radius_sq));
  assign kill = dsum <= CW'(kill_distance_sq);

  // valid bits, write pointer, pipeline flags
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= '0;
      write_pointer <= '0;
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
      if (cmd.clear) begin
        entry_valid   <= '0;
        write_pointer <= '0;
      end else if (cmd.load && !table_full) begin
        entry_valid[write_pointer[IW-1:0]] <= 1'b1;
        write_pointer <= write_pointer + 1'b1;
      end else if (hit && kill) begin
        entry_valid[s2_idx] <= 1'b0;
      end
    end
  end

  // held-back hit: last is known only once the walk is over
  logic          pend_v;
  logic [RW-1:0] pend_res;
  logic          push_en, pend_load, pend_clr;
  logic [RW-1:0] push_data, hit_res;

  assign hit_res = {s2_data, 1'b1, kill, 1'b0, 1'b0};

  always_comb begin
    push_en   = 1'b0;
    push_data = '0;
    pend_load = 1'b0;
    pend_clr  = 1'b0;
    if (cmd.load) begin
      push_en            = 1'b1;
      push_data[B_STATUS] = table_full;
      push_data[B_LAST]  = 1'b1;
    end else if (cmd.clear || cmd.other) begin
      push_en           = 1'b1;
      push_data[B_LAST] = 1'b1;
    end else if (cmd.finish) begin
      push_en = 1'b1;
      if (pend_v) begin
        push_data = pend_res;
        pend_clr  = 1'b1;
      end
      push_data[B_LAST] = 1'b1;
    end else if (hit) begin
      pend_load = 1'b1;
      if (pend_v) begin
        push_en   = 1'b1;
        push_data = pend_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (pend_load) begin
      pend_v <= 1'b1;
    end else if (pend_clr) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_res <= hit_res;
    end
  end

  // result queue
  logic [RW-1:0]      fifo_mem [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] fifo_count;
  logic               pop;
  logic [RW-1:0]      head;
  logic [RSW-1:0]     resv;

  assign pop       = out_valid && out_ready;
  assign out_valid = (fifo_count != '0);
  assign head      = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en) begin
      fifo_mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_en && !pop) begin
        fifo_count <= fifo_count + 1'b1;
      end else if (pop && !push_en) begin
        fifo_count <= fifo_count - 1'b1;
      end
    end
  end

  // every entry in flight or held back owns one queue slot
  assign resv = RSW'(fifo_count) + RSW'(s1_v) + RSW'(s2_v) + RSW'(pend_v);

  assign st.cred_ok   = resv < RSW'(FIFO_DEPTH);
  assign st.cur_valid = entry_valid[idx];
  assign st.busy      = s1_v || s2_v;
  assign st.fifo_full = (fifo_count == FIFO_CW'(FIFO_DEPTH));

  assign found_id = head[RW-1 -: ID_W];
  assign found_x  = head[4+3*W-1 -: W];
  assign found_y  = head[4+2*W-1 -: W];
  assign found_z  = head[4+W-1 -: W];
  assign in_range = head[B_INRANGE];
  assign removed  = head[B_REMOVED];
  assign status   = head[B_STATUS];
  assign last     = head[B_LAST];

endmodule

`default_nettype wire

FILE: tb/sv/tb_attraction_point_radius_prune_top.sv
// Self-checking testbench for attraction_point_radius_prune_top: a table predictor in a
// scoreboard class checks every result of load, query, clear and unused-mode transactions.
// Depends on aprp_pkg and the RTL of the block; reads no files.

module tb_attraction_point_radius_prune_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aprp_pkg::*;

  localparam int POINTS = APRP_POINTS;
  localparam int CW = APRP_COORD_BITS;
  // Longest quiet stretch of a correct run is a query walk or the final settle
  // window; this is many times that.
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = POINTS + 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;   // no meaning, empty result
  localparam logic [CFG_W-1:0] RADIUS_MAX = '1;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     id;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } prune_req_t;

  typedef struct {
    logic [ID_W-1:0]      id;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 in_range;
    logic                 removed;
    logic                 status;
    logic                 last;
  } prune_rsp_t;

  // Point table predictor plus the queue of results it expects, oldest first.
  class prune_scoreboard;
    logic [ID_W-1:0]      tab_id [POINTS];
    logic signed [CW-1:0] tab_x [POINTS];
    logic signed [CW-1:0] tab_y [POINTS];
    logic signed [CW-1:0] tab_z [POINTS];
    bit                   tab_live [POINTS];
    int                   wr_ptr;
    logic [CFG_W-1:0]     influence_sq;
    logic [CFG_W-1:0]     kill_sq;
    prune_rsp_t           expected_q [$];
    int errors, n_in, n_out, n_hit, n_kill, n_full;

    function new();
      foreach (tab_live[i]) tab_live[i] = 1'b0;
      wr_ptr = 0;
      influence_sq = '0;
      kill_sq = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_INFLUENCE) influence_sq = val;
      else if (idx == REG_KILL) kill_sq = val;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // append one result to the tail of the expected queue
    function void add_expected(prune_rsp_t rsp);
      expected_q = {expected_q, rsp};
    endfunction

    // Called once per accepted input transaction.
    function void note_input(prune_req_t req);
      prune_rsp_t blank;
      prune_rsp_t held;
      bit have_hit;
      longint dx, dy, dz, span_sq;
      blank = '{id: '0, x: '0, y: '0, z: '0, in_range: 1'b0, removed: 1'b0,
                status: 1'b0, last: 1'b1};
      have_hit = 1'b0;
      n_in++;
      case (req.mode)
        MODE_LOAD: begin
          if (wr_ptr >= POINTS) begin
            blank.status = 1'b1;
            n_full++;
          end else begin
            tab_id[wr_ptr] = req.id;
            tab_x[wr_ptr] = req.x;
            tab_y[wr_ptr] = req.y;
            tab_z[wr_ptr] = req.z;
            tab_live[wr_ptr] = 1'b1;
            wr_ptr++;
          end
          add_expected(blank);
        end
        MODE_QUERY: begin
          for (int i = 0; i < POINTS; i++) begin
            if (tab_live[i]) begin
              dx = longint'(tab_x[i]) - longint'(req.x);
              dy = longint'(tab_y[i]) - longint'(req.y);
              dz = longint'(tab_z[i]) - longint'(req.z);
              span_sq = dx * dx + dy * dy + dz * dz;
              if (span_sq <= longint'(influence_sq)) begin
                // hold one hit back so the final one can carry last
                if (have_hit) add_expected(held);
                held = '{id: tab_id[i], x: tab_x[i], y: tab_y[i], z: tab_z[i],
                         in_range: 1'b1, removed: span_sq <= longint'(kill_sq),
                         status: 1'b0, last: 1'b0};
                have_hit = 1'b1;
                n_hit++;
                if (held.removed) begin
                  tab_live[i] = 1'b0;
                  n_kill++;
                end
              end
            end
          end
          if (have_hit) begin
            held.last = 1'b1;
            add_expected(held);
          end else begin
            add_expected(blank);
          end
        end
        MODE_CLEAR: begin
          foreach (tab_live[i]) tab_live[i] = 1'b0;
          wr_ptr = 0;
          add_expected(blank);
        end
        default: add_expected(blank);
      endcase
    endfunction

    function void check_result(prune_rsp_t got);
      prune_rsp_t want;
      logic signed [63:0] want_v [8];
      logic signed [63:0] got_v [8];
      string names [8] = '{"found_id", "found_x", "found_y", "found_z",
                            "in_range", "removed", "status", "last"};
      n_out++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, none pending (found_id %0h, last %0b)",
                 $time, got.id, got.last);
        return;
      end
      want = expected_q.pop_front();
      want_v = '{want.id, want.x, want.y, want.z,
                 want.in_range, want.removed, want.status, want.last};
      got_v = '{got.id, got.x, got.y, got.z,
                got.in_range, got.removed, got.status, got.last};
      foreach (want_v[k]) begin
        if (want_v[k] !== got_v[k]) begin
          errors++;
          $display("%0t: %s mismatch, expected %0d, got %0d",
                   $time, names[k], want_v[k], got_v[k]);
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block I/O; every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [MODE_W-1:0]     mode = '0;
  logic [ID_W-1:0]       point_id = '0;
  logic signed [CW-1:0]  pos_x = '0;
  logic signed [CW-1:0]  pos_y = '0;
  logic signed [CW-1:0]  pos_z = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ID_W-1:0]       found_id;
  logic signed [CW-1:0]  found_x;
  logic signed [CW-1:0]  found_y;
  logic signed [CW-1:0]  found_z;
  logic                  in_range;
  logic                  removed;
  logic                  status;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  prune_scoreboard sb;
  bit calm = 1'b0;      // set: neither side idles
  int quiet = 0;        // cycles since the last transaction on any channel
  int n_phases = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  attraction_point_radius_prune_top DUT (
    .clk, .rst,
    .in_valid, .in_ready, .mode, .point_id, .pos_x, .pos_y, .pos_z,
    .out_valid, .out_ready, .found_id, .found_x, .found_y, .found_z,
    .in_range, .removed, .status, .last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Receiver: stalls at random, with odds of about 7 in a hundred, outside calm stretches.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 7);
  end

  // Result monitor: values seen here are the ones the block saw at this edge.
  always @(posedge clk) begin
    prune_rsp_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{id: found_id, x: found_x, y: found_y, z: found_z, in_range: in_range,
              removed: removed, status: status, last: last};
      sb.check_result(got);
    end
  end

  // Watchdog: ends the run when no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int rand_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Each task is entered right after a rising edge and returns at the
  // edge where its transaction was accepted.
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] pid,
                          input int x, input int y, input int z);
    prune_req_t req;
    req = '{mode: m, id: pid, x: CW'(x), y: CW'(y), z: CW'(z)};
    // random idle cycles with valid low before this transaction
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= req.mode;
    point_id <= req.id;
    pos_x <= req.x;
    pos_y <= req.y;
    pos_z <= req.z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(req);
  endtask

  task automatic load_point(input logic [ID_W-1:0] pid, input int x, input int y,
                            input int z);
    send_req(MODE_LOAD, pid, x, y, z);
  endtask

  // the id field is don't-care for queries, so it carries random bits
  task automatic query_at(input int x, input int y, input int z);
    send_req(MODE_QUERY, ID_W'($urandom), x, y, z);
  endtask

  task automatic clear_table();
    send_req(MODE_CLEAR, ID_W'($urandom), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Sender holds off until every expected result is back; block is idle then.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Both registers back to back; valid stays high between the two writes.
  task automatic set_config(input logic [CFG_W-1:0] infl, input logic [CFG_W-1:0] kill);
    cfg_valid <= 1'b1;
    cfg_index <= REG_INFLUENCE;
    cfg_data <= infl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(REG_INFLUENCE, infl);
    cfg_index <= REG_KILL;
    cfg_data <= kill;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(REG_KILL, kill);
    cfg_valid <= 1'b0;
    n_phases++;
  endtask

  // centers stay within +-30000 so a spread of up to 2000 never wraps
  function automatic int near(input int c, input int spread);
    return c + int'($urandom_range(2 * spread)) - spread;
  endfunction

  // Radii on the scale of clustered points half the time, plus both extremes and a random full-width value.
  function automatic logic [CFG_W-1:0] pick_radius();
    case ($urandom_range(5))
      0: return '0;
      1: return RADIUS_MAX;
      2: return CFG_W'({$urandom, $urandom});
      default: return CFG_W'($urandom_range(1 << 24, 1 << 16));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_kill(input logic [CFG_W-1:0] infl);
    case ($urandom_range(4))
      0: return '0;
      1: return RADIUS_MAX;     // kill reaches past the influence radius
      2: return CFG_W'({$urandom, $urandom});
      3: return infl >> 2;
      default: return CFG_W'($urandom_range(1 << 22));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int center_x, center_y, center_z, spread, n_ops;
    logic [CFG_W-1:0] infl;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed, with both radii still at their reset value of zero:
    // only an exact hit influences, and it is removed at once.
    query_at(0, 0, 0);                                  // empty table
    send_req(MODE_UNUSED, 16'hFFFF, -1, -1, -1);        // unused mode
    load_point(16'h0000, -32768, -32768, -32768);
    load_point(16'hFFFF, 32767, 32767, 32767);
    load_point(16'h1234, 100, -200, 300);
    load_point(16'h1234, 101, -200, 300);               // same id, one unit away
    query_at(100, -200, 300);                           // exact hit, removed
    query_at(100, -200, 300);                           // removed slot is gone
    drain();

    // Full-scale influence, no kill beyond exact hits; corner-to-corner distance.
    set_config(RADIUS_MAX, '0);
    query_at(-32768, -32768, -32768);
    query_at(32767, 32767, 32767);
    send_req(MODE_UNUSED, 16'h5AA5, 12345, -12345, 0);
    drain();

    // Kill distance larger than the influence radius.
    set_config(CFG_W'(1 << 20), RADIUS_MAX);
    load_point(16'h8001, 1024, 0, 0);                   // exactly on the radius
    query_at(0, 0, 0);
    clear_table();
    query_at(100, -200, 300);                           // nothing left after clear
    load_point(16'h7FFF, 0, 0, 0);                      // write pointer back at zero
    query_at(0, 0, 1023);
    drain();

    // Long stretch with no idling: fill the table, two refused loads, a query
    // that reports every entry, then show removed slots are not reused.
    calm = 1'b1;
    set_config(RADIUS_MAX, CFG_W'($urandom_range(1 << 22)));
    clear_table();
    center_x = near(0, 30000);
    center_y = near(0, 30000);
    center_z = near(0, 30000);
    repeat (POINTS + 2) begin
      load_point(ID_W'($urandom), near(center_x, 2000), near(center_y, 2000),
                 near(center_z, 2000));
    end
    query_at(center_x, center_y, center_z);
    load_point(ID_W'($urandom), center_x, center_y, center_z);
    query_at(near(center_x, 500), near(center_y, 500), near(center_z, 500));
    clear_table();
    calm = 1'b0;

    // Random episodes: a fresh register setting, usually a cleared table, then
    // loads and queries clustered around one center with some noise mixed in.
    while (sb.n_in < 100) begin
      drain();
      infl = pick_radius();
      set_config(infl, pick_kill(infl));
      center_x = near(0, 30000);
      center_y = near(0, 30000);
      center_z = near(0, 30000);
      spread = $urandom_range(2000, 64);
      if ($urandom_range(3) != 0) clear_table();
      n_ops = $urandom_range(14, 6);
      repeat (n_ops) begin
        case ($urandom_range(99)) inside
          [0:39]: load_point(ID_W'($urandom), near(center_x, spread),
                             near(center_y, spread), near(center_z, spread));
          [40:79]: query_at(near(center_x, spread), near(center_y, spread),
                            near(center_z, spread));
          [80:87]: load_point(ID_W'($urandom), rand_coord(), rand_coord(), rand_coord());
          [88:92]: query_at(rand_coord(), rand_coord(), rand_coord());
          [93:96]: begin
            send_req(MODE_UNUSED, ID_W'($urandom), rand_coord(), rand_coord(),
                     rand_coord());
          end
          default: clear_table();
        endcase
      end
    end

    // Wind down: everything back, then a quiet window to catch stray results.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d input and %0d output transactions over %0d register settings",
             sb.n_in, sb.n_out, n_phases);
    $display("  %0d influencing points reported, %0d removed, %0d loads refused as full",
             sb.n_hit, sb.n_kill, sb.n_full);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
